@@ rtl/cbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CI-V bus frame receiver package
// Byte codes, command table, result record and field widths shared by the
// frame receiver.
// ----------------------------------------------------------------------------
package cbfr_pkg;

  localparam logic [7:0] ByteStart     = 8'hFE;
  localparam logic [7:0] ByteStop      = 8'hFD;
  localparam logic [7:0] AddrBroadcast = 8'h00;
  localparam logic [7:0] CmdExtended   = 8'h1A;
  localparam logic [7:0] SubExtended   = 8'h05;
  localparam logic [3:0] NibbleMask    = 4'hF;

  localparam logic       ModeTick      = 1'b1;

  localparam int unsigned MaxData      = 25;
  localparam int unsigned MinFrameLen  = 6;
  localparam int unsigned StartShort   = 6;
  localparam int unsigned StartTwo     = 7;
  localparam int unsigned StartLong    = 9;
  localparam int unsigned CmdOffset    = 5;
  localparam int unsigned DecimalBase  = 10;
  localparam int unsigned PairWeight   = 100;

  localparam int unsigned CfgIdxW      = 2;
  localparam logic [CfgIdxW-1:0] RegOwnAddress  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeoutTick = 2'd1;

  localparam logic [7:0]  OwnAddressReset = 8'h00;
  localparam logic [15:0] TimeoutReset    = 16'd1000;

  localparam int unsigned CountW = 6;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusData  = 2'd1,
    StatusError = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  source_address;
    logic [2:0]  command_length;
    logic [31:0] command_bytes;
    logic [4:0]  data_count;
    logic [4:0]  data_index;
    logic [7:0]  data_byte;
    logic [31:0] decoded_value;
    logic        last;
  } result_t;

  function automatic logic is_two_byte_cmd(logic [7:0] cmd);
    return cmd inside {8'h07, 8'h0E, 8'h13, 8'h14, 8'h15, 8'h16, 8'h19,
                       8'h1A, 8'h1B, 8'h1C, 8'h1E, 8'h21, 8'h27};
  endfunction

endpackage

@@ rtl/civ_bus_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// CI-V bus frame receiver
// Finds addressed frames in a received byte stream and emits one result transaction
// per data byte (one for a frame without data or in error) with the decoded header and value.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries received bytes (tuser = 0) and time ticks (tuser = 1).
//   m_axis carries results; tlast marks the final result of a frame and
//   tuser holds the status. cfg writes own address (index 0) and the
//   timeout in ticks (index 1); cfg is always ready.
//   A stop byte starts the finish sequence: header checks, then a read
//   and an accumulate step per data byte of a one, two or five byte
//   value, then a read and an output step per result (only an output
//   step for a frame without data). The frame buffer has one write port
//   and one read port and is read one entry per step.
//   Overflow and timeout errors give one result in the cycle after the
//   transaction; a short frame gives it after the header checks. s_axis
//   is held off during the finish sequence and while a result waits that
//   m_axis does not take; a stalled m_axis holds the result register.
//   Reset returns to idle with own address 0 and timeout 1000 ticks; the
//   frame buffer needs no clearing.
// ----------------------------------------------------------------------------
module civ_bus_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // rx_byte
  input  logic [0:0]                   s_axis_tuser,   // mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // source_address, command_length, command_bytes, data_count, data_index,
  // data_byte, decoded_value, zero fill
  output logic [95:0]                  m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,   // status
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cbfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    PhIdle, PhSync, PhCollect, PhFinish, PhValRead, PhValAcc, PhEmitRead, PhEmitOut
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [AW-1:0]               byte_cnt_q, byte_cnt_d;
  logic [15:0]                 tick_cnt_q, tick_cnt_d;
  logic [7:0]                  own_addr_q, own_addr_d;
  logic [15:0]                 timeout_q, timeout_d;
  logic [7:0]                  src_q, src_d;
  logic [31:0]                 cmd_q, cmd_d;
  logic [3:0]                  start_q, start_d;
  logic [cbfr_pkg::CountW-1:0] n_q, n_d;
  logic [31:0]                 acc_q, acc_d;
  logic [31:0]                 mul_q, mul_d;
  logic [2:0]                  val_idx_q, val_idx_d;
  logic [4:0]                  data_idx_q, data_idx_d;
  cbfr_pkg::result_t           res_q, res_d;
  logic                        res_valid_q, res_valid_d;

  logic [7:0]                  buf_mem [BUFFER_DEPTH];
  logic [7:0]                  buf_rd_q;

  logic          rx_phase, out_free, in_fire, cfg_fire, is_tick, full;
  logic [AW-1:0] pos_next, rd_addr;
  logic          wr_en, rd_en;
  logic [2:0]    val_off;
  logic [7:0]    cnt8, start8, n8;
  logic          fin_err;
  logic [7:0]    bcd_pair;
  logic [31:0]   prod, cmd_mask;
  logic          emit_last;

  assign rx_phase = phase_q inside {PhIdle, PhSync, PhCollect};
  assign out_free = !res_valid_q || m_axis_tready;
  assign s_axis_tready = rx_phase && out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign is_tick  = (s_axis_tuser[0] == cbfr_pkg::ModeTick);
  assign full     = (byte_cnt_q >= AW'(BUFFER_DEPTH - 1));
  assign pos_next = byte_cnt_q + AW'(1);
  assign wr_en    = in_fire && !is_tick && (phase_q == PhCollect) && !full;

  assign val_off  = (n_q == cbfr_pkg::CountW'(2)) ? ((val_idx_q == 3'd0) ? 3'd1 : 3'd0)
                                                   : val_idx_q;
  assign rd_en    = (phase_q == PhValRead) || (phase_q == PhEmitRead);
  assign rd_addr  = (phase_q == PhValRead) ? AW'(start_q) + AW'(val_off)
                                           : AW'(start_q) + AW'(data_idx_q);

  always_comb begin
    cnt8   = 8'(byte_cnt_q);
    start8 = 8'(cbfr_pkg::StartShort);
    if (cbfr_pkg::is_two_byte_cmd(cmd_q[7:0])) begin
      start8 = 8'(cbfr_pkg::StartTwo);
    end
    if (cmd_q[7:0] == cbfr_pkg::CmdExtended && cmd_q[15:8] == cbfr_pkg::SubExtended) begin
      start8 = 8'(cbfr_pkg::StartLong);
    end
    n8      = cnt8 - start8;
    fin_err = (cnt8 < 8'(cbfr_pkg::MinFrameLen)) || (cnt8 < start8) ||
              (n8 > 8'(cbfr_pkg::MaxData));
  end

  always_comb begin
    bcd_pair = 8'(8'(buf_rd_q[7:4] & cbfr_pkg::NibbleMask) * 8'(cbfr_pkg::DecimalBase)) +
               8'(buf_rd_q[3:0] & cbfr_pkg::NibbleMask);
    prod     = 32'(32'(bcd_pair) * mul_q);
    case (start_q)
      4'(cbfr_pkg::StartShort): cmd_mask = 32'h0000_00FF;
      4'(cbfr_pkg::StartTwo):   cmd_mask = 32'h0000_FFFF;
      default:                  cmd_mask = 32'hFFFF_FFFF;
    endcase
    emit_last = (n_q == '0) || (cbfr_pkg::CountW'(data_idx_q) + cbfr_pkg::CountW'(1) == n_q);
  end

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    tick_cnt_d  = tick_cnt_q;
    own_addr_d  = own_addr_q;
    timeout_d   = timeout_q;
    src_d       = src_q;
    cmd_d       = cmd_q;
    start_d     = start_q;
    n_d         = n_q;
    acc_d       = acc_q;
    mul_d       = mul_q;
    val_idx_d   = val_idx_q;
    data_idx_d  = data_idx_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !m_axis_tready;

    if (cfg_fire) begin
      if (cfg_index_i == cbfr_pkg::RegOwnAddress) begin
        own_addr_d = cfg_data_i[7:0];
      end else if (cfg_index_i == cbfr_pkg::RegTimeoutTick) begin
        timeout_d = cfg_data_i;
      end
    end

    case (phase_q)
      PhIdle, PhSync, PhCollect: begin
        if (in_fire) begin
          if (is_tick) begin
            if (phase_q != PhIdle) begin
              tick_cnt_d = tick_cnt_q + 16'd1;
              if (tick_cnt_d >= timeout_q || tick_cnt_d == '0) begin
                res_d        = '0;
                res_d.status = cbfr_pkg::StatusError;
                res_d.last   = 1'b1;
                res_valid_d  = 1'b1;
                phase_d      = PhIdle;
                byte_cnt_d   = '0;
              end
            end
          end else if (phase_q == PhIdle) begin
            if (s_axis_tdata == cbfr_pkg::ByteStart) begin
              byte_cnt_d = AW'(1);
              tick_cnt_d = '0;
              phase_d    = PhSync;
            end
          end else if (phase_q == PhSync) begin
            if (s_axis_tdata == cbfr_pkg::ByteStart) begin
              byte_cnt_d = AW'(2);
              phase_d    = PhCollect;
            end else begin
              byte_cnt_d = '0;
              phase_d    = PhIdle;
            end
          end else if (full) begin
            res_d        = '0;
            res_d.status = cbfr_pkg::StatusError;
            res_d.last   = 1'b1;
            res_valid_d  = 1'b1;
            phase_d      = PhIdle;
            byte_cnt_d   = '0;
          end else begin
            byte_cnt_d = pos_next;
            if (pos_next == AW'(4)) src_d = s_axis_tdata;
            if (pos_next == AW'(5)) cmd_d[7:0]   = s_axis_tdata;
            if (pos_next == AW'(6)) cmd_d[15:8]  = s_axis_tdata;
            if (pos_next == AW'(7)) cmd_d[23:16] = s_axis_tdata;
            if (pos_next == AW'(8)) cmd_d[31:24] = s_axis_tdata;
            if (s_axis_tdata == cbfr_pkg::ByteStop) begin
              phase_d = PhFinish;
            end else if (s_axis_tdata == cbfr_pkg::ByteStart ||
                         (pos_next == AW'(3) && s_axis_tdata != cbfr_pkg::AddrBroadcast &&
                          s_axis_tdata != own_addr_q)) begin
              phase_d    = PhIdle;
              byte_cnt_d = '0;
            end
          end
        end
      end
      PhFinish: begin
        if (fin_err) begin
          if (out_free) begin
            res_d        = '0;
            res_d.status = cbfr_pkg::StatusError;
            res_d.last   = 1'b1;
            res_valid_d  = 1'b1;
            phase_d      = PhIdle;
            byte_cnt_d   = '0;
          end
        end else begin
          start_d    = start8[3:0];
          n_d        = n8[cbfr_pkg::CountW-1:0];
          acc_d      = '0;
          mul_d      = 32'd1;
          val_idx_d  = '0;
          data_idx_d = '0;
          if (n8 inside {8'd1, 8'd2, 8'd5}) begin
            phase_d = PhValRead;
          end else if (n8 == 8'd0) begin
            phase_d = PhEmitOut;
          end else begin
            phase_d = PhEmitRead;
          end
        end
      end
      PhValRead: begin
        phase_d = PhValAcc;
      end
      PhValAcc: begin
        acc_d     = (n_q == cbfr_pkg::CountW'(1)) ? 32'(buf_rd_q) : acc_q + prod;
        mul_d     = 32'(mul_q * 32'(cbfr_pkg::PairWeight));
        val_idx_d = val_idx_q + 3'd1;
        if (cbfr_pkg::CountW'(val_idx_d) == n_q) begin
          phase_d = PhEmitRead;
        end else begin
          phase_d = PhValRead;
        end
      end
      PhEmitRead: begin
        phase_d = PhEmitOut;
      end
      PhEmitOut: begin
        if (out_free) begin
          res_d.status         = (n_q == '0) ? cbfr_pkg::StatusOk : cbfr_pkg::StatusData;
          res_d.source_address = src_q;
          res_d.command_length = 3'(start_q - 4'(cbfr_pkg::CmdOffset));
          res_d.command_bytes  = cmd_q & cmd_mask;
          res_d.data_count     = 5'(n_q);
          res_d.data_index     = data_idx_q;
          res_d.data_byte      = (n_q == '0) ? 8'h00 : buf_rd_q;
          res_d.decoded_value  = acc_q;
          res_d.last           = emit_last;
          res_valid_d          = 1'b1;
          if (emit_last) begin
            phase_d    = PhIdle;
            byte_cnt_d = '0;
          end else begin
            data_idx_d = data_idx_q + 5'd1;
            phase_d    = PhEmitRead;
          end
        end
      end
      default: begin
        phase_d    = PhIdle;
        byte_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      byte_cnt_q  <= '0;
      tick_cnt_q  <= '0;
      own_addr_q  <= cbfr_pkg::OwnAddressReset;
      timeout_q   <= cbfr_pkg::TimeoutReset;
      src_q       <= '0;
      cmd_q       <= '0;
      start_q     <= '0;
      n_q         <= '0;
      acc_q       <= '0;
      mul_q       <= '0;
      val_idx_q   <= '0;
      data_idx_q  <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      tick_cnt_q  <= tick_cnt_d;
      own_addr_q  <= own_addr_d;
      timeout_q   <= timeout_d;
      src_q       <= src_d;
      cmd_q       <= cmd_d;
      start_q     <= start_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      mul_q       <= mul_d;
      val_idx_q   <= val_idx_d;
      data_idx_q  <= data_idx_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_mem[pos_next] <= s_axis_tdata;
    end
    if (rd_en) begin
      buf_rd_q <= buf_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {3'b000, res_q.decoded_value, res_q.data_byte, res_q.data_index,
                          res_q.data_count, res_q.command_bytes, res_q.command_length,
                          res_q.source_address};

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == cbfr_pkg::StatusError |-> res_q.last)
    else $error("error result without last");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == cbfr_pkg::StatusData |->
      res_q.data_index < res_q.data_count)
    else $error("data index beyond data count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= AW'(BUFFER_DEPTH - 1))
    else $error("byte count beyond buffer");

endmodule
